>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers for the back engine of the job group dispatch queue
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define JGDQ_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication built on the one above
`define JGDQ_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   `JGDQ_ASSERT(name, clk, rst, (ante) |-> (cons), msg)

`endif

>>> design/jgdq_pkg.sv
// ----------------------------------------------------------------------------
// jgdq_pkg
// types and constants shared by the job group dispatch queue modules
// ----------------------------------------------------------------------------
`default_nettype none

package jgdq_pkg;

   localparam int COUNT_W = 16;
   localparam int SIZE_W  = 7;
   localparam int IDX_W   = 6;
   localparam int GID_W   = 16;

   typedef enum logic {
      ACT_DISPATCH = 1'b0,
      ACT_POP      = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_DISPATCH = 2'd0,
      KIND_JOB      = 2'd1,
      KIND_EMPTY    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POP_READ,
      ST_POP_EMIT
   } back_state_type;

   // classified command handed from front to back
   typedef struct packed {
      action_type          action;
      logic [COUNT_W-1:0]  job_count;
      logic [SIZE_W-1:0]   group_size;
   } cmd_type;

   // one slot of the group ring
   typedef struct packed {
      logic [GID_W-1:0]    gid;
      logic [COUNT_W-1:0]  first;
      logic [IDX_W-1:0]    last_idx;
   } group_entry_type;

   typedef struct packed {
      kind_type            kind;
      logic [COUNT_W-1:0]  job_index;
      logic [GID_W-1:0]    group_number;
      logic [IDX_W-1:0]    index_in_group;
      logic                first_in_group;
      logic                last_in_group;
      logic [GID_W-1:0]    groups_queued;
      logic                queue_full;
      logic                busy_res;
      logic                last;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/jgdq_front.sv
// ----------------------------------------------------------------------------
// jgdq_front
// accepts request transactions, clamps the group size and folds ignored
// dispatches into an empty batch before queueing the command
// ----------------------------------------------------------------------------
`default_nettype none

module jgdq_front #(
   parameter int MAX_GROUP_SIZE = 64
) (
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_action,
   input  wire logic [jgdq_pkg::COUNT_W-1:0]       req_job_count,
   input  wire logic [jgdq_pkg::SIZE_W-1:0]        req_group_size,
   input  wire logic                               fifo_full,
   output logic                                    fifo_push,
   output jgdq_pkg::cmd_type                       fifo_cmd
);

   localparam logic [jgdq_pkg::SIZE_W-1:0] SIZE_MAX = jgdq_pkg::SIZE_W'(MAX_GROUP_SIZE);

   logic [jgdq_pkg::SIZE_W-1:0] size_sat;
   logic                        ignore_req;

   assign req_stall = fifo_full;
   assign fifo_push = req_valid && !fifo_full;

   assign size_sat   = (req_group_size > SIZE_MAX) ? SIZE_MAX : req_group_size;
   assign ignore_req = (req_job_count == '0) || (req_group_size == '0);

   always_comb begin
      fifo_cmd = '0;
      if (req_action == jgdq_pkg::ACT_POP) begin
         fifo_cmd.action = jgdq_pkg::ACT_POP;
      end else begin
         fifo_cmd.action = jgdq_pkg::ACT_DISPATCH;
         // an ignored dispatch becomes a batch of zero jobs: no group is pushed
         fifo_cmd.job_count  = ignore_req ? '0 : req_job_count;
         fifo_cmd.group_size = ignore_req ? jgdq_pkg::SIZE_W'(1) : size_sat;
      end
   end

endmodule

`default_nettype wire

>>> design/jgdq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// jgdq_cmd_fifo
// two-entry command queue that decouples the front from the back engine
// ----------------------------------------------------------------------------
`default_nettype none

module jgdq_cmd_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire jgdq_pkg::cmd_type   push_cmd,
   output logic                     full,
   input  wire logic                pop,
   output logic                     valid,
   output jgdq_pkg::cmd_type        head_cmd
);

   localparam logic [1:0] DEPTH = 2'd2;

   jgdq_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == DEPTH);
   assign valid    = (fill_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> design/jgdq_back.sv
// ----------------------------------------------------------------------------
// jgdq_back
// command engine: pushes groups into the ring one per cycle on a dispatch,
// expands the oldest group into one job per cycle while unstalled on a pop
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jgdq_back #(
   parameter int QUEUE_DEPTH = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                cmd_valid,
   input  wire jgdq_pkg::cmd_type   cmd,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output jgdq_pkg::rsp_type        rsp
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
   localparam int CW  = jgdq_pkg::COUNT_W;
   localparam int SW  = jgdq_pkg::SIZE_W;
   localparam int IW  = jgdq_pkg::IDX_W;

   jgdq_pkg::group_entry_type group_store [QUEUE_DEPTH];
   jgdq_pkg::group_entry_type rd_data_ff;

   jgdq_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]   out_cnt_ff, out_cnt_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [SW-1:0]   size_ff, size_in;
   logic [CW:0]     first_ff, first_in;
   logic [CW-1:0]   gid_ff, gid_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   jgdq_pkg::rsp_type rsp_ff, rsp_in;

   logic            out_free, q_empty, ring_full, disp_done;
   logic [AW-1:0]   wp_next, rp_next;
   logic [CW:0]     remaining;
   logic [SW-1:0]   grp_len;
   jgdq_pkg::group_entry_type new_entry;
   logic            push, do_read, load_cmd, load_out, idx_clear, idx_step;
   jgdq_pkg::rsp_type out_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wp_next   = (wp_ff == PTR_LAST) ? '0 : wp_ff + AW'(1);
   assign rp_next   = (rp_ff == PTR_LAST) ? '0 : rp_ff + AW'(1);
   assign q_empty   = (wp_ff == rp_ff);
   assign ring_full = (wp_next == rp_ff);
   assign disp_done = (first_ff >= {1'b0, count_ff});
   assign remaining = {1'b0, count_ff} - first_ff;
   // the last group of a batch may be short
   assign grp_len   = (remaining < (CW+1)'(size_ff)) ? remaining[SW-1:0] : size_ff;

   assign new_entry.gid      = gid_ff;
   assign new_entry.first    = first_ff[CW-1:0];
   assign new_entry.last_idx = IW'(grp_len - SW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jgdq_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.action == jgdq_pkg::ACT_DISPATCH) begin
                  state_in = jgdq_pkg::ST_DISPATCH;
               end else if (!q_empty) begin
                  state_in = jgdq_pkg::ST_POP_READ;
               end
            end
         end
         jgdq_pkg::ST_DISPATCH: begin
            if ((disp_done || ring_full) && out_free) begin
               state_in = jgdq_pkg::ST_IDLE;
            end
         end
         jgdq_pkg::ST_POP_READ: begin
            state_in = jgdq_pkg::ST_POP_EMIT;
         end
         jgdq_pkg::ST_POP_EMIT: begin
            if (out_free && (idx_ff == rd_data_ff.last_idx)) begin
               state_in = jgdq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jgdq_pkg::ST_IDLE;
         end
      endcase
   end

   // controls and result word
   always_comb begin
      cmd_pop   = 1'b0;
      load_cmd  = 1'b0;
      push      = 1'b0;
      do_read   = 1'b0;
      load_out  = 1'b0;
      idx_clear = 1'b0;
      idx_step  = 1'b0;
      out_data  = '0;
      out_data.busy_res = (out_cnt_ff != '0);
      case (state_ff)
         jgdq_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.action == jgdq_pkg::ACT_DISPATCH) begin
                  cmd_pop  = 1'b1;
                  load_cmd = 1'b1;
               end else if (!q_empty) begin
                  cmd_pop = 1'b1;
               end else if (out_free) begin
                  cmd_pop       = 1'b1;
                  load_out      = 1'b1;
                  out_data.kind = jgdq_pkg::KIND_EMPTY;
                  out_data.last = 1'b1;
               end
            end
         end
         jgdq_pkg::ST_DISPATCH: begin
            if (disp_done || ring_full) begin
               if (out_free) begin
                  load_out               = 1'b1;
                  out_data.kind          = jgdq_pkg::KIND_DISPATCH;
                  out_data.groups_queued = gid_ff;
                  out_data.queue_full    = !disp_done;
                  out_data.last          = 1'b1;
               end
            end else begin
               push = 1'b1;
            end
         end
         jgdq_pkg::ST_POP_READ: begin
            do_read   = 1'b1;
            idx_clear = 1'b1;
         end
         jgdq_pkg::ST_POP_EMIT: begin
            if (out_free) begin
               load_out                = 1'b1;
               idx_step                = 1'b1;
               out_data.kind           = jgdq_pkg::KIND_JOB;
               out_data.job_index      = rd_data_ff.first + CW'(idx_ff);
               out_data.group_number   = rd_data_ff.gid;
               out_data.index_in_group = idx_ff;
               out_data.first_in_group = (idx_ff == '0);
               out_data.last_in_group  = (idx_ff == rd_data_ff.last_idx);
               out_data.last           = (idx_ff == rd_data_ff.last_idx);
            end
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      wp_in      = push ? wp_next : wp_ff;
      rp_in      = do_read ? rp_next : rp_ff;
      out_cnt_in = out_cnt_ff;
      if (push && (out_cnt_ff != '1)) begin
         out_cnt_in = out_cnt_ff + CW'(1);
      end else if (do_read && (out_cnt_ff != '0)) begin
         out_cnt_in = out_cnt_ff - CW'(1);
      end
      count_in = load_cmd ? cmd.job_count : count_ff;
      size_in  = load_cmd ? cmd.group_size : size_ff;
      first_in = first_ff;
      gid_in   = gid_ff;
      if (load_cmd) begin
         first_in = '0;
         gid_in   = '0;
      end else if (push) begin
         first_in = first_ff + (CW+1)'(size_ff);
         gid_in   = gid_ff + CW'(1);
      end
      idx_in = idx_clear ? '0 : (idx_step ? idx_ff + IW'(1) : idx_ff);
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
      rsp_in       = load_out ? out_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jgdq_pkg::ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      size_ff  <= size_in;
      first_ff <= first_in;
      gid_ff   <= gid_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   // group ring storage
   always_ff @(posedge clock) begin
      if (push) begin
         group_store[wp_ff] <= new_entry;
      end
      if (do_read) begin
         rd_data_ff <= group_store[rp_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `JGDQ_ASSERT(a_busy_tracks_ring, clock, reset,
      (out_cnt_ff != '0) == (wp_ff != rp_ff), "outstanding count disagrees with ring")
   `JGDQ_ASSERT_IMPLIES(a_read_nonempty, clock, reset, do_read, !q_empty,
      "group read from an empty ring")
   `JGDQ_ASSERT_IMPLIES(a_emit_in_group, clock, reset,
      state_ff == jgdq_pkg::ST_POP_EMIT, idx_ff <= rd_data_ff.last_idx,
      "job index ran past its group")
   `JGDQ_ASSERT_IMPLIES(a_full_flag, clock, reset,
      load_out && (out_data.kind == jgdq_pkg::KIND_DISPATCH) && out_data.queue_full,
      ring_full, "queue full reported with a free slot")

endmodule

`default_nettype wire

>>> design/job_group_dispatch_queue.sv
// ----------------------------------------------------------------------------
// job_group_dispatch_queue
// splits job batches into groups held in a ring, and expands groups into jobs
// ----------------------------------------------------------------------------
// Requests arrive on req_* (valid/stall): action 0 dispatches req_job_count
// jobs in groups of req_group_size, action 1 pops the oldest group. Results
// leave on rsp_* (valid/stall); rsp_last marks the final result of a request.
// A dispatch answers with one acknowledge giving the groups pushed and a full
// flag; a pop answers with one result per job of the group, or one empty
// result when the ring holds nothing.
// The front takes a request per cycle into a two-entry command queue while
// it is not full; the back engine works one command at a time. A dispatch
// pushes its groups into the ring one per cycle, then sends the acknowledge.
// A pop needs a registered ring read, then emits one job per cycle while
// the result output is not stalled.
// The ring keeps one slot free, so it holds QUEUE_DEPTH - 1 groups.
// Reset empties the ring and the command queue at once; no clearing pass.
// A stalled result holds in the output register; the engine waits to load
// the next result, and the command queue fills and stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module job_group_dispatch_queue #(
   parameter int QUEUE_DEPTH    = 256,
   parameter int MAX_GROUP_SIZE = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic [jgdq_pkg::COUNT_W-1:0]  req_job_count,
   input  wire logic [jgdq_pkg::SIZE_W-1:0]   req_group_size,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_kind,
   output logic [jgdq_pkg::COUNT_W-1:0]       rsp_job_index,
   output logic [jgdq_pkg::GID_W-1:0]         rsp_group_number,
   output logic [jgdq_pkg::IDX_W-1:0]         rsp_index_in_group,
   output logic                               rsp_first_in_group,
   output logic                               rsp_last_in_group,
   output logic [jgdq_pkg::GID_W-1:0]         rsp_groups_queued,
   output logic                               rsp_queue_full,
   output logic                               rsp_busy_res,
   output logic                               rsp_last
);

   logic              fifo_full, fifo_push, fifo_valid, fifo_pop;
   jgdq_pkg::cmd_type front_cmd, head_cmd;
   jgdq_pkg::rsp_type rsp_word;

   jgdq_front #(
      .MAX_GROUP_SIZE (MAX_GROUP_SIZE)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_job_count  (req_job_count),
      .req_group_size (req_group_size),
      .fifo_full      (fifo_full),
      .fifo_push      (fifo_push),
      .fifo_cmd       (front_cmd)
   );

   jgdq_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_cmd (front_cmd),
      .full     (fifo_full),
      .pop      (fifo_pop),
      .valid    (fifo_valid),
      .head_cmd (head_cmd)
   );

   jgdq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (fifo_valid),
      .cmd       (head_cmd),
      .cmd_pop   (fifo_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp_word)
   );

   assign rsp_kind           = rsp_word.kind;
   assign rsp_job_index      = rsp_word.job_index;
   assign rsp_group_number   = rsp_word.group_number;
   assign rsp_index_in_group = rsp_word.index_in_group;
   assign rsp_first_in_group = rsp_word.first_in_group;
   assign rsp_last_in_group  = rsp_word.last_in_group;
   assign rsp_groups_queued  = rsp_word.groups_queued;
   assign rsp_queue_full     = rsp_word.queue_full;
   assign rsp_busy_res       = rsp_word.busy_res;
   assign rsp_last           = rsp_word.last;

endmodule

`default_nettype wire
